// ----- sv/text_console_cursor_engine_top_defines.svh -----
// Assertion macros shared by the verification code of the text console.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCC_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/tcc_pkg.sv -----
package tcc_pkg;

   localparam int SCREEN_COLUMNS = 80;
   localparam int SCREEN_ROWS    = 25;
   localparam int TAB_STOP       = 4;
   localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;

   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int ADDR_W = 11;
   localparam int BYTE_W = 8;
   localparam int TYPE_W = 2;
   localparam int CNT_W  = $clog2(TAB_STOP + 1);

   localparam logic [BYTE_W-1:0] FILL_RESET = 8'h07;

   // Request codes.
   localparam logic [TYPE_W-1:0] REQ_PUT   = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_READ  = 2'd2;

   // Character codes with special handling.
   localparam logic [BYTE_W-1:0] CHAR_BS    = 8'h08;
   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

   typedef struct packed {
      logic capture;
      logic clear_all;
      logic ctrl_move;
      logic tab_load;
      logic plain_load;
      logic put_write;
      logic fill_step;
      logic cell_latch;
      logic rsp_load;
   } tcc_cmd_type;

   typedef struct packed {
      logic [TYPE_W-1:0] req_type;
      logic              is_tab;
      logic              is_ctrl;
      logic              row_valid;
      logic              fill_last;
      logic              cnt_last;
      logic              rsp_free;
   } tcc_status_type;

endpackage

// ----- sv/text_console_cursor_engine_top.sv -----
// Character-cell text console with an 80 x 25 grid of character and color bytes and a cursor.
// Requests enter on the req_ channel (put character, clear screen, read cell); each
// transaction returns one response on the rsp_ channel with the cursor after the request,
// its linear offset for the display's cursor location register, and the read cell.
// csr_wr_en/csr_wr_data set the fill color used by clear and by scroll blanking.
// One request is worked on at a time; req_stall stays high until its response is queued.
// Clear, newline, carriage return, backspace and an undefined request code go from dispatch
// straight to finish; a printable character or read also passes through the plain or read
// state, and a tab writes its spaces in the plain state. The first write into a row that was
// blanked by clear or scroll first writes the whole row out. A new request is taken in the
// cycle after the previous response has been queued; the single write port of the cell
// stores sets the pace of row blanking and tab spaces.
// Reset (synchronous) empties the grid, homes the cursor and sets the fill color to 7 at
// once; there is no clearing pass. When the receiver stalls, the response holds in the
// output register, the next request can still be accepted and worked on, and that request
// waits for the output register before it finishes.
module text_console_cursor_engine_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tcc_pkg::TYPE_W-1:0]    req_type,
   input  logic [tcc_pkg::BYTE_W-1:0]    req_char_code,
   input  logic [tcc_pkg::COL_W-1:0]     req_read_col,
   input  logic [tcc_pkg::ROW_W-1:0]     req_read_row,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tcc_pkg::COL_W-1:0]     rsp_cursor_col,
   output logic [tcc_pkg::ROW_W-1:0]     rsp_cursor_row,
   output logic [tcc_pkg::ADDR_W-1:0]    rsp_cursor_offset,
   output logic [tcc_pkg::BYTE_W-1:0]    rsp_cell_char,
   output logic [tcc_pkg::BYTE_W-1:0]    rsp_cell_color,
   input  logic                          csr_wr_en,
   input  logic [tcc_pkg::BYTE_W-1:0]    csr_wr_data
);
   import tcc_pkg::*;

   // Commands flow from the controller to the datapath, status flows back.
   tcc_cmd_type    cmd;
   tcc_status_type status;

   // The controller sequences each transaction: dispatch, cell reads, row blanking, character writes,
   // and the hand-off of the response into the output register.
   tcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the cursor, the ring of grid rows with per-row blank flags, the two
   // cell stores and the output register.
   tcc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_type          (req_type),
      .req_char_code     (req_char_code),
      .req_read_col      (req_read_col),
      .req_read_row      (req_read_row),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_cursor_col    (rsp_cursor_col),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_offset (rsp_cursor_offset),
      .rsp_cell_char     (rsp_cell_char),
      .rsp_cell_color    (rsp_cell_color),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

endmodule

// ----- sv/tcc_ctrl.sv -----
module tcc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  tcc_pkg::tcc_status_type status,
   output tcc_pkg::tcc_cmd_type    cmd
);
   import tcc_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DISPATCH = 3'd1;
   localparam logic [2:0] ST_READ     = 3'd2;
   localparam logic [2:0] ST_PLAIN    = 3'd3;
   localparam logic [2:0] ST_FILL     = 3'd4;
   localparam logic [2:0] ST_FINISH   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = reset || (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !reset) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (status.req_type)
               REQ_CLEAR: begin
                  cmd.clear_all = 1'b1;
                  state_in      = ST_FINISH;
               end
               REQ_READ: begin
                  state_in = ST_READ;
               end
               REQ_PUT: begin
                  if (status.is_tab) begin
                     cmd.tab_load = 1'b1;
                     state_in     = ST_PLAIN;
                  end else if (status.is_ctrl) begin
                     cmd.ctrl_move = 1'b1;
                     state_in      = ST_FINISH;
                  end else begin
                     cmd.plain_load = 1'b1;
                     state_in       = ST_PLAIN;
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_READ: begin
            cmd.cell_latch = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_PLAIN: begin
            // A row blanked by clear or scroll is written out before its first character.
            if (!status.row_valid) begin
               state_in = ST_FILL;
            end else begin
               cmd.put_write = 1'b1;
               if (status.cnt_last) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               state_in = ST_PLAIN;
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- sv/tcc_datapath.sv -----
module tcc_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  tcc_pkg::tcc_cmd_type          cmd,
   output tcc_pkg::tcc_status_type       status,
   input  logic [tcc_pkg::TYPE_W-1:0]    req_type,
   input  logic [tcc_pkg::BYTE_W-1:0]    req_char_code,
   input  logic [tcc_pkg::COL_W-1:0]     req_read_col,
   input  logic [tcc_pkg::ROW_W-1:0]     req_read_row,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [tcc_pkg::COL_W-1:0]     rsp_cursor_col,
   output logic [tcc_pkg::ROW_W-1:0]     rsp_cursor_row,
   output logic [tcc_pkg::ADDR_W-1:0]    rsp_cursor_offset,
   output logic [tcc_pkg::BYTE_W-1:0]    rsp_cell_char,
   output logic [tcc_pkg::BYTE_W-1:0]    rsp_cell_color,
   input  logic                          csr_wr_en,
   input  logic [tcc_pkg::BYTE_W-1:0]    csr_wr_data
);
   import tcc_pkg::*;

   localparam logic [ROW_W:0]    ROWS_WIDE = (ROW_W + 1)'(SCREEN_ROWS);
   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(SCREEN_ROWS - 1);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(SCREEN_COLUMNS - 1);

   // Logical row to physical row: the grid is kept as a ring of rows starting at top.
   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                 input logic [ROW_W-1:0] top);
      logic [ROW_W:0] sum;
      sum = {1'b0, row} + {1'b0, top};
      if (sum >= ROWS_WIDE) begin
         sum = sum - ROWS_WIDE;
      end
      return sum[ROW_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      return ADDR_W'(row) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(col);
   endfunction

   logic [BYTE_W-1:0] fill_color_ff, fill_color_in;

   logic [TYPE_W-1:0] req_type_ff;
   logic [BYTE_W-1:0] char_ff;
   logic [COL_W-1:0]  rcol_ff;
   logic [ROW_W-1:0]  rrow_ff;

   logic [COL_W-1:0]       cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]       cur_row_ff, cur_row_in;
   logic [ROW_W-1:0]       top_ff, top_in;
   logic [SCREEN_ROWS-1:0] row_valid_ff, row_valid_in;
   logic [BYTE_W-1:0]      row_fill_ff [SCREEN_ROWS];
   logic [BYTE_W-1:0]      row_fill_in [SCREEN_ROWS];

   logic [BYTE_W-1:0] put_char_ff, put_char_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [COL_W-1:0]  fill_col_ff, fill_col_in;

   logic [BYTE_W-1:0] cell_char_ff, cell_char_in;
   logic [BYTE_W-1:0] cell_color_ff, cell_color_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]  rsp_col_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [ADDR_W-1:0] rsp_off_ff;
   logic [BYTE_W-1:0] rsp_char_ff;
   logic [BYTE_W-1:0] rsp_color_ff;

   logic [BYTE_W-1:0] char_mem  [CELL_COUNT];
   logic [BYTE_W-1:0] color_mem [CELL_COUNT];
   logic [BYTE_W-1:0] rd_char_ff;
   logic [BYTE_W-1:0] rd_color_ff;

   logic              req_in_range;
   logic [ROW_W-1:0]  cur_phys;
   logic [ROW_W-1:0]  req_phys;
   logic [ROW_W-1:0]  look_row;
   logic              look_valid;
   logic [BYTE_W-1:0] look_fill;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0] wr_char;
   logic              fill_last;
   logic              scroll;
   logic [CNT_W-1:0]  tab_cnt;

   assign req_in_range = (rcol_ff < COL_W'(SCREEN_COLUMNS)) && (rrow_ff < ROW_W'(SCREEN_ROWS));
   assign cur_phys     = phys_row(cur_row_ff, top_ff);
   assign req_phys     = req_in_range ? phys_row(rrow_ff, top_ff) : '0;
   assign look_row     = (req_type_ff == REQ_READ) ? req_phys : cur_phys;
   assign look_valid   = row_valid_ff[look_row];
   assign look_fill    = row_fill_ff[look_row];
   assign fill_last    = (fill_col_ff == LAST_COL);
   assign tab_cnt      = CNT_W'(TAB_STOP) - CNT_W'(cur_col_ff % COL_W'(TAB_STOP));

   assign wr_addr = cmd.fill_step ? cell_addr(cur_phys, fill_col_ff)
                                  : cell_addr(cur_phys, cur_col_ff);
   assign wr_char = cmd.fill_step ? '0 : put_char_ff;
   assign rd_addr = req_in_range ? cell_addr(req_phys, rcol_ff) : '0;

   assign fill_color_in = csr_wr_en ? csr_wr_data : fill_color_ff;
   assign fill_col_in   = cmd.fill_step ? fill_col_ff + 1'b1 : '0;

   // Cursor, row ring and blank-row bookkeeping.
   always_comb begin
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      top_in       = top_ff;
      row_valid_in = row_valid_ff;
      row_fill_in  = row_fill_ff;
      scroll       = 1'b0;
      if (cmd.clear_all) begin
         cur_col_in   = '0;
         cur_row_in   = '0;
         top_in       = '0;
         row_valid_in = '0;
         row_fill_in  = '{default: fill_color_ff};
      end else if (cmd.ctrl_move) begin
         if (char_ff == CHAR_NL) begin
            cur_col_in = '0;
            if (cur_row_ff == LAST_ROW) begin
               scroll = 1'b1;
            end else begin
               cur_row_in = cur_row_ff + 1'b1;
            end
         end else if (char_ff == CHAR_CR) begin
            cur_col_in = '0;
         end else begin
            // Backspace: no erase, wraps to the previous row, stays at the origin.
            if (cur_col_ff != '0) begin
               cur_col_in = cur_col_ff - 1'b1;
            end else if (cur_row_ff != '0) begin
               cur_col_in = LAST_COL;
               cur_row_in = cur_row_ff - 1'b1;
            end
         end
      end else if (cmd.put_write) begin
         if (cur_col_ff == LAST_COL) begin
            cur_col_in = '0;
            if (cur_row_ff == LAST_ROW) begin
               scroll = 1'b1;
            end else begin
               cur_row_in = cur_row_ff + 1'b1;
            end
         end else begin
            cur_col_in = cur_col_ff + 1'b1;
         end
      end
      // Scrolling rotates the ring; the old top row becomes the blank bottom row.
      if (scroll) begin
         row_valid_in[top_ff] = 1'b0;
         row_fill_in[top_ff]  = fill_color_ff;
         top_in               = (top_ff == LAST_ROW) ? '0 : top_ff + 1'b1;
      end
      if (cmd.fill_step && fill_last) begin
         row_valid_in[cur_phys] = 1'b1;
      end
   end

   always_comb begin
      put_char_in = put_char_ff;
      cnt_in      = cnt_ff;
      if (cmd.tab_load) begin
         put_char_in = CHAR_SPACE;
         cnt_in      = tab_cnt;
      end else if (cmd.plain_load) begin
         put_char_in = char_ff;
         cnt_in      = CNT_W'(1);
      end else if (cmd.put_write) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_comb begin
      cell_char_in  = cell_char_ff;
      cell_color_in = cell_color_ff;
      if (cmd.capture) begin
         cell_char_in  = '0;
         cell_color_in = '0;
      end else if (cmd.cell_latch && req_in_range) begin
         cell_char_in  = look_valid ? rd_char_ff : '0;
         cell_color_in = look_valid ? rd_color_ff : look_fill;
      end
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_color_ff <= FILL_RESET;
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         top_ff        <= '0;
         row_valid_ff  <= '0;
         row_fill_ff   <= '{default: FILL_RESET};
         fill_col_ff   <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fill_color_ff <= fill_color_in;
         cur_col_ff    <= cur_col_in;
         cur_row_ff    <= cur_row_in;
         top_ff        <= top_in;
         row_valid_ff  <= row_valid_in;
         row_fill_ff   <= row_fill_in;
         fill_col_ff   <= fill_col_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff <= req_type;
         char_ff     <= req_char_code;
         rcol_ff     <= req_read_col;
         rrow_ff     <= req_read_row;
      end
      put_char_ff   <= put_char_in;
      cell_char_ff  <= cell_char_in;
      cell_color_ff <= cell_color_in;
      if (cmd.rsp_load) begin
         rsp_col_ff   <= cur_col_ff;
         rsp_row_ff   <= cur_row_ff;
         rsp_off_ff   <= cell_addr(cur_row_ff, cur_col_ff);
         rsp_char_ff  <= cell_char_ff;
         rsp_color_ff <= cell_color_ff;
      end
   end

   // Cell stores: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.put_write || cmd.fill_step) begin
         char_mem[wr_addr] <= wr_char;
      end
      if (cmd.fill_step) begin
         color_mem[wr_addr] <= look_fill;
      end
      rd_char_ff  <= char_mem[rd_addr];
      rd_color_ff <= color_mem[rd_addr];
   end

   assign status.req_type  = req_type_ff;
   assign status.is_tab    = (char_ff == CHAR_TAB);
   assign status.is_ctrl   = char_ff inside {CHAR_NL, CHAR_CR, CHAR_BS};
   assign status.row_valid = look_valid;
   assign status.fill_last = fill_last;
   assign status.cnt_last  = (cnt_ff == CNT_W'(1));
   assign status.rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cursor_col    = rsp_col_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cursor_offset = rsp_off_ff;
   assign rsp_cell_char     = rsp_char_ff;
   assign rsp_cell_color    = rsp_color_ff;

endmodule

// ----- sv/tcc_checker.sv -----
`include "text_console_cursor_engine_top_defines.svh"

module tcc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [tcc_pkg::COL_W-1:0]     rsp_cursor_col,
   input logic [tcc_pkg::ROW_W-1:0]     rsp_cursor_row,
   input logic [tcc_pkg::ADDR_W-1:0]    rsp_cursor_offset,
   input logic [tcc_pkg::BYTE_W-1:0]    rsp_cell_char,
   input logic [tcc_pkg::BYTE_W-1:0]    rsp_cell_color
);
   import tcc_pkg::*;

   // A stalled response keeps its contents.
   `TCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_cursor_offset) && $stable(rsp_cell_char) && $stable(rsp_cell_color), "stalled response changed")

   // The cursor always lies on the grid.
   `TCC_ASSERT_HOLDS(a_cursor_range, clock, reset, rsp_valid, (rsp_cursor_col < COL_W'(SCREEN_COLUMNS)) && (rsp_cursor_row < ROW_W'(SCREEN_ROWS)), "cursor off the grid")

   // The offset matches the reported row and column.
   `TCC_ASSERT_HOLDS(a_offset, clock, reset, rsp_valid, rsp_cursor_offset == ADDR_W'(rsp_cursor_row) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(rsp_cursor_col), "cursor offset mismatch")

   // Only one request is in work at a time.
   `TCC_ASSERT_NEXT(a_one_in_work, clock, reset, req_valid && !req_stall, req_stall, "second request taken while busy")

   // No response is pending right after reset.
   `TCC_ASSERT_HOLDS(a_reset_empty, clock, reset, $past(reset), !rsp_valid, "response pending after reset")

endmodule

bind text_console_cursor_engine_top tcc_checker u_tcc_checker (.*);
